>>> sv/utf8v_pkg.sv
// Shared types and constants for the UTF-8 text validator.
package utf8v_pkg;

  // Default counter width and register reset values
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned CAP_W           = 16;
  localparam int unsigned LEN_OUT_W       = 16;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam logic [CAP_W-1:0] CAP_RESET  = 16'd256;

  // Configuration register indexes
  typedef enum logic {
    CFG_MAX_CAPACITY = 1'b0,
    CFG_MULTILINE    = 1'b1
  } cfg_index_t;

  // Byte classes
  localparam logic [7:0] CTRL_LIMIT = 8'd32;
  localparam logic [7:0] CHAR_DEL   = 8'd127;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] ASCII_END  = 8'd128;
  localparam logic [7:0] LEAD2_LO   = 8'd194;
  localparam logic [7:0] LEAD2_HI   = 8'd223;
  localparam logic [7:0] LEAD3_LO   = 8'd224;
  localparam logic [7:0] LEAD3_HI   = 8'd239;
  localparam logic [7:0] LEAD4_LO   = 8'd240;
  localparam logic [7:0] LEAD4_HI   = 8'd244;

  // Code point limits
  localparam int unsigned CP_W = 21;
  localparam logic [CP_W-1:0] CP_MAX      = 21'd1114111;
  localparam logic [CP_W-1:0] SURR_LO     = 21'd55296;
  localparam logic [CP_W-1:0] SURR_HI     = 21'd57343;
  localparam logic [CP_W-1:0] C1_LO       = 21'd128;
  localparam logic [CP_W-1:0] C1_HI       = 21'd159;
  localparam logic [CP_W-1:0] MIN_CP_2B   = 21'd128;
  localparam logic [CP_W-1:0] MIN_CP_3B   = 21'd2048;
  localparam logic [CP_W-1:0] MIN_CP_4B   = 21'd65536;

  // Lowest legal code point class of the open sequence
  typedef enum logic [1:0] {
    MIN_2BYTE = 2'd0,
    MIN_3BYTE = 2'd1,
    MIN_4BYTE = 2'd2
  } min_class_t;

  // Decode state carried from byte to byte
  typedef struct packed {
    logic               error_seen;
    logic [1:0]         pending;
    logic [CP_W-1:0]    accum;
    min_class_t         min_class;
  } dec_state_t;

  localparam dec_state_t DEC_CLEAR = '{
    error_seen: 1'b0, pending: 2'd0, accum: '0, min_class: MIN_2BYTE
  };

endpackage

>>> sv/utf8v_step.sv
// One-byte decode step: next UTF-8 decode state from the current state and a byte.
module utf8v_step (
  input  utf8v_pkg::dec_state_t cur_state,
  input  logic [7:0]            byte_in,
  input  logic                  multiline,
  input  logic                  cnt_full,
  output utf8v_pkg::dec_state_t nxt_state
);
  import utf8v_pkg::*;

  logic [CP_W-1:0] acc_new;
  logic [1:0]      pend_new;
  logic [CP_W-1:0] min_cp;
  logic            cp_bad;
  logic            ws_ok;

  // Append the six payload bits of a continuation byte
  assign acc_new  = {cur_state.accum[CP_W-7:0], byte_in[5:0]};
  assign pend_new = cur_state.pending - 2'd1;

  // Pick the lowest legal code point for the sequence length
  always_comb begin
    case (cur_state.min_class)
      MIN_2BYTE: min_cp = MIN_CP_2B;
      MIN_3BYTE: min_cp = MIN_CP_3B;
      MIN_4BYTE: min_cp = MIN_CP_4B;
      default:   min_cp = MIN_CP_2B;
    endcase
  end

  // Reject overlong, too large, surrogate and C1 code points
  assign cp_bad = (acc_new < min_cp) || (acc_new > CP_MAX) ||
                  (acc_new >= SURR_LO && acc_new <= SURR_HI) ||
                  (acc_new >= C1_LO && acc_new <= C1_HI);

  assign ws_ok = multiline &&
                 (byte_in == CHAR_TAB || byte_in == CHAR_LF || byte_in == CHAR_CR);

  // Advance the decoder; hold everything once an error has latched
  always_comb begin
    nxt_state = cur_state;
    if (cnt_full) begin
      nxt_state.error_seen = 1'b1;
    end
    if (!nxt_state.error_seen) begin
      if (cur_state.pending != 2'd0) begin
        if (byte_in[7:6] != 2'b10) begin
          nxt_state.error_seen = 1'b1;
        end else begin
          nxt_state.accum   = acc_new;
          nxt_state.pending = pend_new;
          if (pend_new == 2'd0 && cp_bad) begin
            nxt_state.error_seen = 1'b1;
          end
        end
      end else if (byte_in < CTRL_LIMIT || byte_in == CHAR_DEL) begin
        if (!ws_ok) begin
          nxt_state.error_seen = 1'b1;
        end
      end else if (byte_in < ASCII_END) begin
        nxt_state.error_seen = 1'b0;
      end else if (byte_in >= LEAD2_LO && byte_in <= LEAD2_HI) begin
        nxt_state.accum     = {{(CP_W-5){1'b0}}, byte_in[4:0]};
        nxt_state.pending   = 2'd1;
        nxt_state.min_class = MIN_2BYTE;
      end else if (byte_in >= LEAD3_LO && byte_in <= LEAD3_HI) begin
        nxt_state.accum     = {{(CP_W-4){1'b0}}, byte_in[3:0]};
        nxt_state.pending   = 2'd2;
        nxt_state.min_class = MIN_3BYTE;
      end else if (byte_in >= LEAD4_LO && byte_in <= LEAD4_HI) begin
        nxt_state.accum     = {{(CP_W-3){1'b0}}, byte_in[2:0]};
        nxt_state.pending   = 2'd3;
        nxt_state.min_class = MIN_4BYTE;
      end else begin
        nxt_state.error_seen = 1'b1;
      end
    end
  end

endmodule

>>> sv/utf8_text_validator.sv
// Top level of the streaming UTF-8 text validator.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | text_byte, has_byte, last_byte
//   out_    | output    | out_valid/out_stall| text_valid, text_length
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One byte per cycle while in_stall is low: an item is registered on acceptance,
// decoded by the byte step from the input register, and a verdict lands in the
// output register when the last item leaves the input register. Items without
// last_byte never wait on the output. Reset (synchronous, rst_n low) clears the
// pipeline and text state and restores max_capacity 256, multiline off.
// A stalled verdict holds the decode stage only when it too carries a last item.
module utf8_text_validator #(
  parameter int unsigned LENGTH_BITS = utf8v_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [utf8v_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_text_byte,
  input  logic                             in_has_byte,
  input  logic                             in_last_byte,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_text_valid,
  output logic [utf8v_pkg::LEN_OUT_W-1:0]  out_text_length
);
  import utf8v_pkg::*;

  localparam int unsigned CMP_W = (LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W;

  // Configuration registers
  logic [CAP_W-1:0]       max_capacity_r;
  logic                   multiline_r;

  // Input register
  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_has_r;
  logic                   s1_last_r;

  // Text state
  dec_state_t             dec_r, dec_nxt, dec_step;
  logic [LENGTH_BITS-1:0] count_r, count_nxt, count_step;
  logic                   cnt_full;

  // Output register
  logic                   out_valid_r;
  logic                   out_ok_r, out_ok_nxt;
  logic [LEN_OUT_W-1:0]   out_len_r, out_len_nxt;

  logic                   s1_fire;
  logic                   in_fire;
  logic [CMP_W-1:0]       count_wide;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_capacity_r <= CAP_RESET;
      multiline_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_CAPACITY: max_capacity_r <= cfg_wdata[CAP_W-1:0];
        CFG_MULTILINE:    multiline_r    <= cfg_wdata[0];
        default:          multiline_r    <= multiline_r;
      endcase
    end
  end

  // Drain the input register unless a verdict cannot be placed
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_text_byte;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Decode one byte
  assign cnt_full = (count_r == {LENGTH_BITS{1'b1}});

  utf8v_step u_step (
    .cur_state (dec_r),
    .byte_in   (s1_byte_r),
    .multiline (multiline_r),
    .cnt_full  (cnt_full),
    .nxt_state (dec_step)
  );

  always_comb begin
    if (s1_has_r) begin
      count_step = cnt_full ? count_r : count_r + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    end else begin
      count_step = count_r;
    end
  end

  assign count_wide = CMP_W'(s1_has_r ? count_step : count_r);

  // Form the verdict from the state after this item's byte
  always_comb begin
    dec_nxt     = s1_has_r ? dec_step : dec_r;
    count_nxt   = count_step;
    out_ok_nxt  = !dec_nxt.error_seen && (dec_nxt.pending == 2'd0) &&
                  (multiline_r || (count_wide != '0)) &&
                  (count_wide < CMP_W'(max_capacity_r));
    out_len_nxt = (count_wide > CMP_W'({LEN_OUT_W{1'b1}})) ?
                  {LEN_OUT_W{1'b1}} : count_wide[LEN_OUT_W-1:0];
    if (s1_last_r) begin
      dec_nxt   = DEC_CLEAR;
      count_nxt = '0;
    end
  end

  // Advance text state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r   <= DEC_CLEAR;
      count_r <= '0;
    end else if (s1_fire) begin
      dec_r   <= dec_nxt;
      count_r <= count_nxt;
    end
  end

  // Load or drop the verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_ok_r  <= out_ok_nxt;
      out_len_r <= out_len_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_text_valid  = out_ok_r;
  assign out_text_length = out_len_r;

endmodule
